[hdl/clm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular list manager package
// Shared constants, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;

  typedef enum logic [1:0] {
    MODE_FRONT  = 2'd0,
    MODE_END    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_INS_LINK,
    S_LOAD,
    S_DEL_WALK,
    S_DEL_FIX,
    S_LIST_WALK,
    S_RESULT
  } state_t;

  // Read address source for the linked store.
  typedef enum logic [1:0] {
    RD_HOLD,
    RD_HEAD,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    latch_op;
    rd_sel_t rd_sel;
    logic    ins_write;
    logic    ins_link;
    logic    del_fix;
    logic    set_status;
    status_t status_code;
    logic    emit_item;
    logic    emit_status;
  } dp_cmd_t;

  typedef struct packed {
    mode_t op_mode;
    logic  empty;
    logic  full;
    logic  match;
    logic  walk_end;
    logic  out_free;
  } dp_sts_t;

endpackage

[hdl/clm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clm_ram #(
  parameter int WIDTH = clm_pkg::VALUE_W,
  parameter int DEPTH = clm_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/clm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular list manager controller
// Sequences inserts, deletes and list walks, and issues datapath commands.
// ----------------------------------------------------------------------------
module clm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic [1:0]        mode,
  output logic              cmd_stall,
  input  clm_pkg::dp_sts_t  sts,
  output clm_pkg::dp_cmd_t  ctl
);

  import clm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (mode_t'(mode) == MODE_FRONT || mode_t'(mode) == MODE_END) begin
            state_next = S_INSERT;
          end else begin
            state_next = S_LOAD;
          end
        end
      end
      S_INSERT: begin
        if (sts.full || sts.empty) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_INS_LINK;
        end
      end
      S_INS_LINK: state_next = S_RESULT;
      S_LOAD: begin
        if (sts.empty) begin
          state_next = S_RESULT;
        end else if (sts.op_mode == MODE_DELETE) begin
          state_next = S_DEL_WALK;
        end else begin
          state_next = S_LIST_WALK;
        end
      end
      S_DEL_WALK: begin
        if (sts.match) begin
          state_next = S_DEL_FIX;
        end else if (sts.walk_end) begin
          state_next = S_RESULT;
        end
      end
      S_DEL_FIX: state_next = S_RESULT;
      S_LIST_WALK: begin
        if (sts.out_free && sts.walk_end) begin
          state_next = S_IDLE;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.rd_sel      = RD_HOLD;
    ctl.status_code = ST_OK;
    cmd_stall       = 1'b1;
    unique case (state)
      S_IDLE: begin
        cmd_stall    = 1'b0;
        ctl.latch_op = cmd_valid;
      end
      S_INSERT: begin
        if (sts.full) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_FULL;
        end else begin
          ctl.ins_write = 1'b1;
          // The first entry links to itself, so no second link write is needed.
          ctl.set_status = sts.empty;
        end
      end
      S_INS_LINK: begin
        ctl.ins_link   = 1'b1;
        ctl.set_status = 1'b1;
      end
      S_LOAD: begin
        if (sts.empty) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_EMPTY;
        end else begin
          ctl.rd_sel = RD_HEAD;
        end
      end
      S_DEL_WALK: begin
        if (!sts.match) begin
          if (sts.walk_end) begin
            ctl.set_status  = 1'b1;
            ctl.status_code = ST_NOT_FOUND;
          end else begin
            ctl.rd_sel = RD_NEXT;
          end
        end
      end
      S_DEL_FIX: begin
        ctl.del_fix    = 1'b1;
        ctl.set_status = 1'b1;
      end
      S_LIST_WALK: begin
        if (sts.out_free) begin
          ctl.emit_item = 1'b1;
          if (!sts.walk_end) begin
            ctl.rd_sel = RD_NEXT;
          end
        end
      end
      S_RESULT: begin
        ctl.emit_status = sts.out_free;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

[hdl/clm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular list manager datapath
// Linked store, free map, list pointers, walk registers and result register.
// ----------------------------------------------------------------------------
module clm_datapath #(
  parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  clm_pkg::dp_cmd_t                   ctl,
  output clm_pkg::dp_sts_t                   sts,
  input  logic [1:0]                         mode,
  input  logic signed [clm_pkg::VALUE_W-1:0] value,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [1:0]                         status,
  output logic signed [clm_pkg::VALUE_W-1:0] item,
  output logic                               item_valid,
  output logic                               last
);

  import clm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  mode_t                     op_mode;
  logic signed [VALUE_W-1:0] op_value;
  status_t                   res_code;

  logic [CAPACITY-1:0] free_map;
  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [AW-1:0]       cur;
  logic [AW-1:0]       prev;
  logic [CW-1:0]       step;
  logic [AW-1:0]       slot;

  logic [CAPACITY-1:0] low_free;
  logic [AW-1:0]       slot_idx;
  logic [AW-1:0]       rd_addr;
  logic [VALUE_W-1:0]  val_rdata;
  logic [AW-1:0]       link_rdata;
  logic                lnk_we;
  logic [AW-1:0]       lnk_waddr;
  logic [AW-1:0]       lnk_wdata;
  logic                empty;
  logic                one_left;
  logic                walk_end;
  logic                out_free;

  assign empty    = (count == '0);
  assign one_left = (count == CW'(1));
  assign walk_end = ((step + CW'(1)) == count);
  assign out_free = !res_valid || !res_stall;

  // A new value takes the lowest-numbered free entry.
  assign low_free = free_map & (~free_map + CAPACITY'(1));

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (low_free[i]) begin
        slot_idx = slot_idx | AW'(i);
      end
    end
  end

  always_comb begin
    case (ctl.rd_sel)
      RD_HEAD: rd_addr = head;
      RD_NEXT: rd_addr = link_rdata;
      default: rd_addr = cur;
    endcase
  end

  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = tail;
    lnk_wdata = slot;
    if (ctl.ins_write) begin
      lnk_we    = 1'b1;
      lnk_waddr = slot_idx;
      lnk_wdata = empty ? slot_idx : head;
    end else if (ctl.ins_link) begin
      lnk_we = 1'b1;
    end else if (ctl.del_fix && !one_left) begin
      lnk_we = 1'b1;
      if (cur == head) begin
        lnk_waddr = tail;
        lnk_wdata = link_rdata;
      end else if (cur == tail) begin
        lnk_waddr = prev;
        lnk_wdata = head;
      end else begin
        lnk_waddr = prev;
        lnk_wdata = link_rdata;
      end
    end
  end

  clm_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_values (
    .clk  (clk),
    .we   (ctl.ins_write),
    .waddr(slot_idx),
    .wdata(op_value),
    .raddr(rd_addr),
    .rdata(val_rdata)
  );

  clm_ram #(
    .WIDTH(AW),
    .DEPTH(CAPACITY)
  ) u_links (
    .clk  (clk),
    .we   (lnk_we),
    .waddr(lnk_waddr),
    .wdata(lnk_wdata),
    .raddr(rd_addr),
    .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (ctl.ins_write) begin
      free_map[slot_idx] <= 1'b0;
      if (empty) begin
        head  <= slot_idx;
        tail  <= slot_idx;
        count <= count + CW'(1);
      end
    end else if (ctl.ins_link) begin
      if (op_mode == MODE_FRONT) begin
        head <= slot;
      end else begin
        tail <= slot;
      end
      count <= count + CW'(1);
    end else if (ctl.del_fix) begin
      free_map[cur] <= 1'b1;
      count         <= count - CW'(1);
      if (one_left) begin
        head <= '0;
        tail <= '0;
      end else if (cur == head) begin
        head <= link_rdata;
      end else if (cur == tail) begin
        tail <= prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_op) begin
      op_mode  <= mode_t'(mode);
      op_value <= value;
    end
    if (ctl.ins_write) begin
      slot <= slot_idx;
    end
    if (ctl.set_status) begin
      res_code <= ctl.status_code;
    end
    case (ctl.rd_sel)
      RD_HEAD: begin
        cur  <= head;
        prev <= tail;
        step <= '0;
      end
      RD_NEXT: begin
        cur  <= link_rdata;
        prev <= cur;
        step <= step + CW'(1);
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // Result register: a new result is loaded only when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit_item || ctl.emit_status) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_item) begin
      status     <= ST_OK;
      item       <= val_rdata;
      item_valid <= 1'b1;
      last       <= walk_end;
    end else if (ctl.emit_status) begin
      status     <= res_code;
      item       <= '0;
      item_valid <= 1'b0;
      last       <= 1'b1;
    end
  end

  assign sts.op_mode  = op_mode;
  assign sts.empty    = empty;
  assign sts.full     = (count == CW'(CAPACITY));
  assign sts.match    = (val_rdata == op_value);
  assign sts.walk_end = walk_end;
  assign sts.out_free = out_free;

endmodule

[hdl/circular_list_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular list manager
// Ordered circular list of signed values in a linked store with a free map.
// ----------------------------------------------------------------------------
// Each command transfer is one operation: insert at front, insert at end,
// delete the first entry equal to the value, or list every value from head
// to tail. One command is worked on at a time. An insert writes the entry
// and its link in S_INSERT and links it into the list in S_INS_LINK, or,
// if the store is full (no write) or the list was empty, goes to S_RESULT.
// Delete and list walk the linked store one entry per cycle through its
// registered read port, a list only while the result side does not stall;
// a list gives count items, the last marked by last. A new command is taken
// as soon as the last result of the previous one sits in the result register.
module circular_list_manager #(
  parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [1:0]                         mode,
  input  logic signed [clm_pkg::VALUE_W-1:0] value,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [1:0]                         status,
  output logic signed [clm_pkg::VALUE_W-1:0] item,
  output logic                               item_valid,
  output logic                               last
);

  import clm_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  clm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .mode     (mode),
    .cmd_stall(cmd_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  clm_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .mode      (mode),
    .value     (value),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .item      (item),
    .item_valid(item_valid),
    .last      (last)
  );

`ifndef NO_ASSERTIONS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit_item || ctl.emit_status) |-> sts.out_free)
    else $error("Result loaded while the result register was occupied.");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("Command port did not stall after a command transfer.");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_write |-> !sts.full)
    else $error("Entry written into a full store.");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.ins_write, ctl.ins_link, ctl.del_fix}))
    else $error("More than one list update in the same cycle.");
`endif

endmodule
